// File: rtl/lrt_pkg.sv
// ----------------------------------------------------------------------------
// LRU tracker package
// Field widths, operation and status codes, and the command word that the
// control logic broadcasts to every cell of the recency chain.
// ----------------------------------------------------------------------------
package lrt_pkg;

   localparam int OP_BITS       = 2;
   localparam int KEY_PORT_BITS = 32;
   localparam int STATUS_BITS   = 3;
   localparam int OCC_BITS      = 5;

   typedef enum logic [OP_BITS-1:0] {
      OP_ACCESS = 2'd0,
      OP_EVICT  = 2'd1,
      OP_REMOVE = 2'd2
   } lrt_op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_HIT       = 3'd0,
      ST_INSERTED  = 3'd1,
      ST_EVICTED   = 3'd2,
      ST_REMOVED   = 3'd3,
      ST_EMPTY     = 3'd4,
      ST_NOT_FOUND = 3'd5,
      ST_FULL      = 3'd6
   } lrt_status_type;

   typedef struct packed {
      logic hit_move;
      logic insert;
      logic remove;
      logic evict;
   } lrt_cmd_type;

endpackage

// File: rtl/lrt_req_if.sv
// ----------------------------------------------------------------------------
// LRU tracker request channel
// Valid/ready channel that carries one operation and its lookup key.
// ----------------------------------------------------------------------------
interface lrt_req_if
   import lrt_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [OP_BITS-1:0]       operation;
   logic [KEY_PORT_BITS-1:0] lookup_key;

   modport source (output valid, output operation, output lookup_key, input ready);
   modport sink (input valid, input operation, input lookup_key, output ready);
endinterface

// File: rtl/lrt_rsp_if.sv
// ----------------------------------------------------------------------------
// LRU tracker response channel
// Valid/ready channel that carries the status, evicted key and occupancy.
// ----------------------------------------------------------------------------
interface lrt_rsp_if
   import lrt_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [STATUS_BITS-1:0]   status;
   logic [KEY_PORT_BITS-1:0] evicted_key;
   logic [OCC_BITS-1:0]      occupancy;

   modport source (output valid, output status, output evicted_key, output occupancy,
                   input ready);
   modport sink (input valid, input status, input evicted_key, input occupancy,
                 output ready);
endinterface

// File: rtl/lru_replacement_tracker.sv
// ----------------------------------------------------------------------------
// LRU replacement tracker
// Keeps the recency order of up to ENTRIES keys in a chain of cells.
// ----------------------------------------------------------------------------
// The request channel carries an operation (access, evict, remove) and a key.
// Access touches a tracked key or, unless full, inserts a new one as most
// recent; evict drops the least recent key and returns it; remove drops a
// named key. Every request transfer produces exactly one response transfer
// with the status, the evicted key (zero unless evicting) and the new occupancy.
// The key compare runs in parallel in all cells and the chain shifts in the
// same cycle, so a request is answered in the cycle after its transfer and
// one request is taken every cycle unless the receiver stalls. The response
// sits in an output register; while the receiver stalls, a new request is
// taken only once the waiting response is taken in the same cycle. Reset
// empties the chain and drops any pending response. Keys are held at
// KEY_BITS bits; the request key is truncated or zero-extended to that width.
// ----------------------------------------------------------------------------
module lru_replacement_tracker
   import lrt_pkg::*;
#(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   lrt_req_if.sink   req_bus,
   lrt_rsp_if.source rsp_bus
);

   localparam int CNT_BITS = $clog2(ENTRIES + 1);

   logic [KEY_BITS-1:0]      cell_key   [ENTRIES];
   logic [ENTRIES-1:0]       cell_valid;
   logic [KEY_BITS-1:0]      tail_chain [ENTRIES+1];
   logic [ENTRIES:0]         below_chain;
   logic [ENTRIES:0]         above_chain;

   logic [KEY_BITS+KEY_PORT_BITS-1:0] key_wide;
   logic [KEY_BITS-1:0]               key;
   logic [KEY_PORT_BITS+KEY_BITS-1:0] victim_wide;

   logic                 accept;
   logic                 any_match;
   logic                 full;
   logic                 empty;
   lrt_cmd_type          cmd;
   lrt_status_type       status;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [CNT_BITS+OCC_BITS-1:0] occ_wide;

   logic                     rsp_valid_ff;
   logic [STATUS_BITS-1:0]   rsp_status_ff;
   logic [KEY_PORT_BITS-1:0] rsp_key_ff, rsp_key_in;
   logic [OCC_BITS-1:0]      rsp_occ_ff;

   assign key_wide = {{KEY_BITS{1'b0}}, req_bus.lookup_key};
   assign key      = key_wide[KEY_BITS-1:0];

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   assign below_chain[ENTRIES] = 1'b0;
   assign above_chain[0]       = 1'b0;
   assign tail_chain[ENTRIES]  = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic [KEY_BITS-1:0] prev_key, next_key;
      logic                prev_valid, next_valid;

      if (i == 0) begin : g_head
         assign prev_key   = key;
         assign prev_valid = 1'b1;
      end else begin : g_mid_prev
         assign prev_key   = cell_key[i-1];
         assign prev_valid = cell_valid[i-1];
      end

      if (i == ENTRIES - 1) begin : g_tail
         assign next_key   = '0;
         assign next_valid = 1'b0;
      end else begin : g_mid_next
         assign next_key   = cell_key[i+1];
         assign next_valid = cell_valid[i+1];
      end

      lrt_cell #(
         .KEY_BITS(KEY_BITS)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .cmd             (cmd),
         .lookup_key      (key),
         .prev_key        (prev_key),
         .prev_valid      (prev_valid),
         .next_key        (next_key),
         .next_valid      (next_valid),
         .match_below_in  (below_chain[i+1]),
         .match_below_out (below_chain[i]),
         .match_above_in  (above_chain[i]),
         .match_above_out (above_chain[i+1]),
         .tail_key_in     (tail_chain[i+1]),
         .tail_key_out    (tail_chain[i]),
         .key             (cell_key[i]),
         .valid           (cell_valid[i])
      );
   end

   assign any_match = below_chain[0];
   assign full      = (count_ff == CNT_BITS'(ENTRIES));
   assign empty     = (count_ff == '0);

   always_comb begin
      cmd      = '0;
      status   = ST_NOT_FOUND;
      count_in = count_ff;
      unique case (lrt_op_type'(req_bus.operation))
         OP_ACCESS: begin
            if (any_match) begin
               status       = ST_HIT;
               cmd.hit_move = accept;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               status     = ST_INSERTED;
               cmd.insert = accept;
               count_in   = count_ff + CNT_BITS'(1);
            end
         end
         OP_EVICT: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               status    = ST_EVICTED;
               cmd.evict = accept;
               count_in  = count_ff - CNT_BITS'(1);
            end
         end
         OP_REMOVE: begin
            if (any_match) begin
               status     = ST_REMOVED;
               cmd.remove = accept;
               count_in   = count_ff - CNT_BITS'(1);
            end
         end
         default: begin
            status = ST_NOT_FOUND;
         end
      endcase
   end

   assign victim_wide = {{KEY_PORT_BITS{1'b0}}, tail_chain[0]};
   assign rsp_key_in  = (status == ST_EVICTED) ? victim_wide[KEY_PORT_BITS-1:0] : '0;
   assign occ_wide    = {{OCC_BITS{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= status;
         rsp_key_ff    <= rsp_key_in;
         rsp_occ_ff    <= occ_wide[OCC_BITS-1:0];
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.evicted_key = rsp_key_ff;
   assign rsp_bus.occupancy   = rsp_occ_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(ENTRIES))
      else $error("Occupancy count exceeds the number of entries.");

   a_valid_matches_count : assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff))
      else $error("Number of valid cells differs from the occupancy count.");

   a_valid_contiguous : assert property (@(posedge clock) disable iff (reset)
      ((cell_valid & (cell_valid + ENTRIES'(1))) == '0))
      else $error("Valid cells do not form a contiguous run from the head.");

   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> (count_ff == $past(count_ff) + CNT_BITS'(1)))
      else $error("An insert did not grow the occupancy by one.");

endmodule

// File: rtl/lrt_cell.sv
// ----------------------------------------------------------------------------
// LRU tracker recency cell
// One position of the recency chain. Position zero is most recent. A cell
// takes its neighbor's key when the chain shifts, and clears when it is the
// least recent entry during an eviction.
// ----------------------------------------------------------------------------
module lrt_cell
   import lrt_pkg::*;
#(
   parameter int KEY_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  lrt_cmd_type         cmd,
   input  logic [KEY_BITS-1:0] lookup_key,
   input  logic [KEY_BITS-1:0] prev_key,
   input  logic                prev_valid,
   input  logic [KEY_BITS-1:0] next_key,
   input  logic                next_valid,
   input  logic                match_below_in,
   output logic                match_below_out,
   input  logic                match_above_in,
   output logic                match_above_out,
   input  logic [KEY_BITS-1:0] tail_key_in,
   output logic [KEY_BITS-1:0] tail_key_out,
   output logic [KEY_BITS-1:0] key,
   output logic                valid
);

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                valid_ff, valid_in;
   logic                match;
   logic                is_tail;
   logic                shift_down;
   logic                shift_up;
   logic                clear;

   assign match           = valid_ff && (key_ff == lookup_key);
   assign is_tail         = valid_ff && !next_valid;
   assign match_below_out = match || match_below_in;
   assign match_above_out = match || match_above_in;
   assign tail_key_out    = tail_key_in | (is_tail ? key_ff : '0);

   assign shift_down = cmd.insert || (cmd.hit_move && match_below_out);
   assign shift_up   = cmd.remove && match_above_out;
   assign clear      = cmd.evict && is_tail;

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      if (shift_down) begin
         key_in   = prev_key;
         valid_in = prev_valid;
      end else if (shift_up) begin
         key_in   = next_key;
         valid_in = next_valid;
      end else if (clear) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key   = key_ff;
   assign valid = valid_ff;

endmodule
